### rtl/core/teb_pkg.sv
// Shared types and constants for the timestamp event builder.
package teb_pkg;
  localparam int SRC_W   = 5;
  localparam int SEC_W   = 32;
  localparam int NSEC_W  = 30;
  localparam int POS_W   = 6;
  localparam int DATA_W  = 64;
  localparam int CNT_W   = 5;
  localparam int WCNT_W  = 7;

  localparam logic CFG_SOURCE_COUNT = 1'b0;
  localparam logic CFG_EVENT_WORDS  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDNEW,
    ST_CMPNEW,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_MASK_RD,
    ST_MASK_CHK,
    ST_WORD,
    ST_LAST_RD,
    ST_LAST_CHK,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;
endpackage

### rtl/core/teb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module teb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/timestamp_event_builder_top.sv
// Top level of the timestamp event builder: sequencer, slot ring and event store.
// Sequence: a continuing fragment word goes straight to ST_WORD; a first word reads and
// compares the newest slot, then each slot visited by a backward search (at most one
// lap of the ring); a kept fragment's last word rewrites its slot mask, and when that
// completes an event its words stream one per cycle. Reads are registered. After reset a
// clearing pass sweeps the slot ring while busy stays high; results cannot be stalled.
module timestamp_event_builder_top #(
  parameter int RING_DEPTH  = 1024,
  parameter int MAX_SOURCES = 21,
  parameter int MAX_WORDS   = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [teb_pkg::SRC_W-1:0]  in_source_id,
  input  logic [teb_pkg::SEC_W-1:0]  in_stamp_sec,
  input  logic [teb_pkg::NSEC_W-1:0] in_stamp_nsec,
  input  logic [teb_pkg::POS_W-1:0]  in_word_pos,
  input  logic [teb_pkg::DATA_W-1:0] in_payload,
  input  logic                       in_frag_last,
  output logic                       out_valid,
  output logic [teb_pkg::SEC_W-1:0]  out_event_sec,
  output logic [teb_pkg::NSEC_W-1:0] out_event_nsec,
  output logic [teb_pkg::DATA_W-1:0] out_event_word,
  output logic                       out_event_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [0:0]                 cfg_index,
  input  logic [6:0]                 cfg_data
);
  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int WPS_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int ADDR_W = SLOT_W + WPS_W;
  localparam int REC_W  = teb_pkg::SEC_W + teb_pkg::NSEC_W + MAX_SOURCES;

  teb_pkg::state_t state_r, state_nxt;

  logic [teb_pkg::CNT_W-1:0]  src_cnt_r;
  logic [teb_pkg::WCNT_W-1:0] words_cnt_r;
  logic [SLOT_W-1:0] newest_r, newest_nxt, fslot_r, fslot_nxt, idx_r, idx_nxt;
  logic              factive_r, factive_nxt, fdrop_r, fdrop_nxt;
  logic [teb_pkg::SRC_W-1:0]  fsrc_r, fsrc_nxt;
  logic [teb_pkg::SEC_W-1:0]  sec_r;
  logic [teb_pkg::NSEC_W-1:0] nsec_r;
  logic [teb_pkg::POS_W-1:0]  pos_r;
  logic [teb_pkg::DATA_W-1:0] pay_r;
  logic                       last_r;
  logic [teb_pkg::WCNT_W-1:0] k_r, k_nxt;
  logic [teb_pkg::SRC_W-1:0]  in_src_r;

  // slot record: {sec, nsec, mask}
  logic              rec_we;
  logic [SLOT_W-1:0] rec_waddr, rec_raddr;
  logic [REC_W-1:0]  rec_wdata, rec_rdata;
  logic              st_we;
  logic [ADDR_W-1:0] st_waddr, st_raddr;
  logic [teb_pkg::DATA_W-1:0] st_rdata;

  teb_ram #(.WIDTH(REC_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata));

  teb_ram #(.WIDTH(teb_pkg::DATA_W), .DEPTH(RING_DEPTH * (1 << WPS_W))) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(pay_r),
    .raddr(st_raddr), .rdata(st_rdata));

  logic [teb_pkg::SEC_W-1:0]  r_sec;
  logic [teb_pkg::NSEC_W-1:0] r_nsec;
  logic [MAX_SOURCES-1:0]     r_mask;
  assign r_sec  = rec_rdata[REC_W-1 -: teb_pkg::SEC_W];
  assign r_nsec = rec_rdata[MAX_SOURCES +: teb_pkg::NSEC_W];
  assign r_mask = rec_rdata[MAX_SOURCES-1:0];

  // shared stamp compare
  logic s_older, s_newer;
  assign s_older = (r_sec < sec_r) || ((r_sec == sec_r) && (r_nsec < nsec_r));
  assign s_newer = (r_sec > sec_r) || ((r_sec == sec_r) && (r_nsec > nsec_r));

  logic [teb_pkg::CNT_W-1:0]  nsrc;
  logic [teb_pkg::WCNT_W-1:0] nwords;
  logic [MAX_SOURCES-1:0]     full, src_bit, in_bit, new_mask;
  always_comb begin
    nsrc = src_cnt_r;
    if (nsrc == '0) nsrc = teb_pkg::CNT_W'(1);
    if (32'(nsrc) > MAX_SOURCES) nsrc = teb_pkg::CNT_W'(MAX_SOURCES);
    nwords = words_cnt_r;
    if (nwords == '0) nwords = teb_pkg::WCNT_W'(1);
    if (32'(nwords) > MAX_WORDS) nwords = teb_pkg::WCNT_W'(MAX_WORDS);
    for (int i = 0; i < MAX_SOURCES; i++) begin
      full[i]    = (i < 32'(nsrc));
      src_bit[i] = (32'(fsrc_r) == i);
      in_bit[i]  = (32'(in_src_r) == i);
    end
    new_mask = r_mask | src_bit;
  end

  logic src_bad, src_dup;
  assign src_bad = (in_src_r >= nsrc);
  assign src_dup = |(r_mask & in_bit);

  assign busy      = (state_r != teb_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r   <= teb_pkg::CNT_W'(1);
      words_cnt_r <= teb_pkg::WCNT_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        teb_pkg::CFG_SOURCE_COUNT: src_cnt_r   <= cfg_data[teb_pkg::CNT_W-1:0];
        teb_pkg::CFG_EVENT_WORDS:  words_cnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      sec_r    <= in_stamp_sec;
      nsec_r   <= in_stamp_nsec;
      pos_r    <= in_word_pos;
      pay_r    <= in_payload;
      last_r   <= in_frag_last;
      in_src_r <= in_source_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= teb_pkg::ST_CLEAR;
      newest_r  <= '0;
      fslot_r   <= '0;
      idx_r     <= '0;
      factive_r <= 1'b0;
      fdrop_r   <= 1'b0;
      fsrc_r    <= '0;
      k_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      newest_r  <= newest_nxt;
      fslot_r   <= fslot_nxt;
      idx_r     <= idx_nxt;
      factive_r <= factive_nxt;
      fdrop_r   <= fdrop_nxt;
      fsrc_r    <= fsrc_nxt;
      k_r       <= k_nxt;
    end
  end

  logic [SLOT_W-1:0] idx_inc, idx_dec;
  assign idx_inc = (32'(idx_r) == RING_DEPTH - 1) ? '0 : idx_r + SLOT_W'(1);
  assign idx_dec = (idx_r == '0) ? SLOT_W'(RING_DEPTH - 1) : idx_r - SLOT_W'(1);

  always_comb begin
    state_nxt   = state_r;
    newest_nxt  = newest_r;
    fslot_nxt   = fslot_r;
    idx_nxt     = idx_r;
    factive_nxt = factive_r;
    fdrop_nxt   = fdrop_r;
    fsrc_nxt    = fsrc_r;
    k_nxt       = k_r;
    rec_we      = 1'b0;
    rec_waddr   = idx_r;
    rec_wdata   = '0;
    rec_raddr   = idx_r;
    st_we       = 1'b0;
    st_waddr    = {fslot_r, pos_r[WPS_W-1:0]};
    st_raddr    = {fslot_r, k_r[WPS_W-1:0]};
    out_valid   = 1'b0;
    out_event_last = 1'b0;
    case (state_r)
      teb_pkg::ST_CLEAR: begin
        rec_we  = 1'b1;
        idx_nxt = idx_inc;
        if (32'(idx_r) == RING_DEPTH - 1) state_nxt = teb_pkg::ST_IDLE;
      end
      teb_pkg::ST_IDLE: begin
        if (start) begin
          if (factive_r) state_nxt = teb_pkg::ST_WORD;
          else begin
            idx_nxt   = newest_r;
            state_nxt = teb_pkg::ST_RDNEW;
          end
        end
      end
      teb_pkg::ST_RDNEW: begin
        rec_raddr = idx_r;
        state_nxt = teb_pkg::ST_CMPNEW;
      end
      teb_pkg::ST_CMPNEW: begin
        fsrc_nxt    = in_src_r;
        factive_nxt = 1'b1;
        if (s_older) begin
          // advance the ring into a fresh slot
          rec_we     = 1'b1;
          rec_waddr  = idx_inc;
          rec_wdata  = {sec_r, nsec_r, {MAX_SOURCES{1'b0}}};
          newest_nxt = idx_inc;
          fslot_nxt  = idx_inc;
          fdrop_nxt  = src_bad;
          state_nxt  = teb_pkg::ST_WORD;
        end else if (s_newer) begin
          idx_nxt   = idx_dec;
          state_nxt = teb_pkg::ST_SRCH_RD;
        end else begin
          fslot_nxt = idx_r;
          fdrop_nxt = src_bad || src_dup;
          state_nxt = teb_pkg::ST_WORD;
        end
      end
      teb_pkg::ST_SRCH_RD: begin
        rec_raddr = idx_r;
        state_nxt = teb_pkg::ST_SRCH_CMP;
      end
      teb_pkg::ST_SRCH_CMP: begin
        if (s_newer && idx_r != newest_r) begin
          idx_nxt   = idx_dec;
          state_nxt = teb_pkg::ST_SRCH_RD;
        end else begin
          fslot_nxt = idx_r;
          if (s_newer || s_older || src_bad) fdrop_nxt = 1'b1;
          else fdrop_nxt = src_dup;
          state_nxt = teb_pkg::ST_WORD;
        end
      end
      teb_pkg::ST_WORD: begin
        if (!fdrop_r && (7'(pos_r) < nwords)) st_we = 1'b1;
        if (last_r) begin
          factive_nxt = 1'b0;
          if (fdrop_r) begin
            fdrop_nxt = 1'b0;
            state_nxt = teb_pkg::ST_IDLE;
          end else state_nxt = teb_pkg::ST_LAST_RD;
        end else state_nxt = teb_pkg::ST_IDLE;
        rec_raddr = fslot_r;
      end
      teb_pkg::ST_LAST_RD: begin
        rec_raddr = fslot_r;
        state_nxt = teb_pkg::ST_LAST_CHK;
      end
      teb_pkg::ST_LAST_CHK: begin
        rec_raddr = fslot_r;
        rec_we    = 1'b1;
        rec_waddr = fslot_r;
        rec_wdata = {r_sec, r_nsec, new_mask};
        k_nxt     = '0;
        if (new_mask == full && r_mask != full) state_nxt = teb_pkg::ST_EMIT_RD;
        else state_nxt = teb_pkg::ST_IDLE;
      end
      teb_pkg::ST_EMIT_RD: begin
        rec_raddr = fslot_r;
        k_nxt     = k_r + teb_pkg::WCNT_W'(1);
        st_raddr  = {fslot_r, k_r[WPS_W-1:0]};
        state_nxt = teb_pkg::ST_EMIT;
      end
      teb_pkg::ST_EMIT: begin
        rec_raddr      = fslot_r;
        out_valid      = 1'b1;
        out_event_last = (k_r == nwords);
        st_raddr       = {fslot_r, k_r[WPS_W-1:0]};
        k_nxt          = k_r + teb_pkg::WCNT_W'(1);
        if (k_r == nwords) state_nxt = teb_pkg::ST_IDLE;
      end
      default: state_nxt = teb_pkg::ST_IDLE;
    endcase
  end

  assign out_event_sec  = r_sec;
  assign out_event_nsec = r_nsec;
  assign out_event_word = st_rdata;

`ifndef SYNTHESIS
  a_no_start_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == teb_pkg::ST_CLEAR) |-> busy)
    else $error("idle during clear");
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result while idle");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_last) |=> !out_valid)
    else $error("results after last");
  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == teb_pkg::ST_WORD && fdrop_r) |-> !st_we)
    else $error("dropped word stored");
`endif
endmodule
